// ----- rtl/packet_signature_matcher_defines.svh -----
// Assertion macros shared by the signature matcher RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PACKET_SIGNATURE_MATCHER_DEFINES_SVH
`define PACKET_SIGNATURE_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/psm_pkg.sv -----
// Shared types, constants and match functions for the signature matcher.
// No dependencies.
package psm_pkg;

	localparam int unsigned SCAN_BYTES_DEF = 256;
	localparam int unsigned LIMIT_W = 9;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
	localparam int unsigned TAG_W = 32;

	// Signature slots in the found-flag vector
	localparam int unsigned SIG_SCRIPT  = 0;
	localparam int unsigned SIG_RUNTIME = 1;
	localparam int unsigned SIG_EXECUTE = 2;
	localparam int unsigned SIG_CLI     = 3;
	localparam int unsigned SIG_FILE    = 4;
	localparam int unsigned SIG_COUNT   = 5;

	localparam int unsigned LEN_SCRIPT  = 7;
	localparam int unsigned LEN_RUNTIME = 18;
	localparam int unsigned LEN_EXECUTE = 7;
	localparam int unsigned LEN_CLI     = 13;
	localparam int unsigned LEN_FILE    = 2;

	// Longest signature sets the window: current byte plus WIN_BYTES-1 cells
	localparam int unsigned WIN_BYTES = LEN_RUNTIME;

	// Packed text, last character in the low byte
	localparam logic [8*LEN_SCRIPT-1:0]  TXT_SCRIPT  = "/script";
	localparam logic [8*LEN_RUNTIME-1:0] TXT_RUNTIME = "Runtime.getRuntime";
	localparam logic [8*LEN_EXECUTE-1:0] TXT_EXECUTE = "execute";
	localparam logic [8*LEN_CLI-1:0]     TXT_CLI     = "/cli?remoting";
	localparam logic [8*LEN_FILE-1:0]    TXT_FILE    = "@/";

	typedef enum logic [1:0] {
		VERDICT_NONE           = 2'd0,
		VERDICT_SCRIPT_RUNTIME = 2'd1,
		VERDICT_SCRIPT_EXECUTE = 2'd2,
		VERDICT_CLI_FILE       = 2'd3
	} verdict_t;

	typedef logic [SIG_COUNT-1:0] sig_flags_t;

	// Window w holds the newest byte in w[7:0]
	function automatic sig_flags_t sig_hits(input logic [8*WIN_BYTES-1:0] w);
		sig_flags_t h;
		h[SIG_SCRIPT]  = (w[8*LEN_SCRIPT-1:0]  == TXT_SCRIPT);
		h[SIG_RUNTIME] = (w[8*LEN_RUNTIME-1:0] == TXT_RUNTIME);
		h[SIG_EXECUTE] = (w[8*LEN_EXECUTE-1:0] == TXT_EXECUTE);
		h[SIG_CLI]     = (w[8*LEN_CLI-1:0]     == TXT_CLI);
		h[SIG_FILE]    = (w[8*LEN_FILE-1:0]    == TXT_FILE);
		return h;
	endfunction

	function automatic verdict_t verdict_of(input sig_flags_t f);
		verdict_t v;
		if (f[SIG_SCRIPT] && f[SIG_RUNTIME]) begin
			v = VERDICT_SCRIPT_RUNTIME;
		end else if (f[SIG_SCRIPT] && f[SIG_EXECUTE]) begin
			v = VERDICT_SCRIPT_EXECUTE;
		end else if (f[SIG_CLI] && f[SIG_FILE]) begin
			v = VERDICT_CLI_FILE;
		end else begin
			v = VERDICT_NONE;
		end
		return v;
	endfunction

endpackage

// ----- rtl/psm_if.sv -----
// Valid/ready channel interfaces for payload bytes and verdicts.
// Depends on psm_pkg.
interface psm_in_if import psm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [7:0]       data_byte;
	logic             last_byte;
	logic [TAG_W-1:0] context_tag;

	modport source (output valid, data_byte, last_byte, context_tag, input ready);
	modport sink   (input valid, data_byte, last_byte, context_tag, output ready);
endinterface

interface psm_out_if import psm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       verdict;
	logic [TAG_W-1:0] tag_out;

	modport source (output valid, verdict, tag_out, input ready);
	modport sink   (input valid, verdict, tag_out, output ready);
endinterface

// ----- rtl/psm_cell.sv -----
// One byte cell of the sliding match window; passes its byte to the next cell.
// No package dependencies.
module psm_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       clear,
	input  logic [7:0] byte_in,
	output logic [7:0] byte_out
);
	logic [7:0] byte_q;

	// clear wins: window restarts empty for each packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'd0;
		end else if (clear) begin
			byte_q <= 8'd0;
		end else if (shift) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
endmodule

// ----- rtl/packet_signature_matcher.sv -----
// Top level: byte-serial five-signature matcher with per-packet verdict.
// Depends on psm_pkg, psm_if, psm_cell and packet_signature_matcher_defines.svh.
//
//   channel | dir | handshake       | payload
//   --------+-----+-----------------+-------------------------------------
//   pkt     | in  | valid/ready     | data_byte, last_byte, context_tag
//   res     | out | valid/ready     | verdict, tag_out (one per packet)
//   cfg     | in  | cfg_we          | cfg_wdata = scan_limit
//
// One beat per clock: compare, flag update and verdict all sit in the cycle the
// beat is taken; the verdict is registered and shows in the cycle after the last beat.
// Throughput is set by the single output register: input stalls only while a
// verdict is held with res.ready low. Reset clears window, flags, count and output
// valid and loads scan_limit with 256; no clearing pass is needed.
`include "packet_signature_matcher_defines.svh"

module packet_signature_matcher import psm_pkg::*; #(
	parameter int unsigned SCAN_BYTES = SCAN_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	psm_in_if.sink             pkt,
	psm_out_if.source          res,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);
	localparam int unsigned CNT_W = $clog2(SCAN_BYTES + 1);
	localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int unsigned CELLS = WIN_BYTES - 1;

	logic [LIMIT_W-1:0]     limit_q;
	logic [CNT_W-1:0]       count_q;
	sig_flags_t             flags_q;
	logic                   out_valid_q;
	verdict_t               verdict_q;
	logic [TAG_W-1:0]       tag_q;

	logic                   acc;
	logic                   do_scan;
	logic                   pkt_end;
	logic [7:0]             win [CELLS];
	logic [8*WIN_BYTES-1:0] win_flat;
	sig_flags_t             flags_nxt;

	// ---- beat acceptance ----
	// Output register frees when the sink takes the verdict this cycle.
	assign pkt.ready = !out_valid_q || res.ready;
	assign acc       = pkt.valid && pkt.ready;
	assign pkt_end   = acc && pkt.last_byte;
	// Byte is scanned only inside min(scan_limit, SCAN_BYTES).
	assign do_scan   = acc && (CMP_W'(count_q) < CMP_W'(limit_q))
	                       && (CMP_W'(count_q) < CMP_W'(SCAN_BYTES));

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// ---- window cell chain ----
	// Cell 0 takes the incoming byte, cell i takes cell i-1.
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		if (i == 0) begin : g_head
			psm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (do_scan),
				.clear    (pkt_end),
				.byte_in  (pkt.data_byte),
				.byte_out (win[i])
			);
		end else begin : g_body
			psm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (do_scan),
				.clear    (pkt_end),
				.byte_in  (win[i-1]),
				.byte_out (win[i])
			);
		end
	end

	// Newest byte in the low lane. Cleared cells hold zero, which no
	// signature contains, so a hit never reaches past the packet start.
	always_comb begin
		win_flat[7:0] = pkt.data_byte;
		for (int i = 0; i < CELLS; i++) begin
			win_flat[8*(i+1) +: 8] = win[i];
		end
	end

	assign flags_nxt = flags_q | (do_scan ? sig_hits(win_flat) : '0);

	// ---- per-packet state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			count_q <= '0;
		end else if (pkt_end) begin
			flags_q <= '0;
			count_q <= '0;
		end else if (do_scan) begin
			flags_q <= flags_nxt;
			count_q <= count_q + CNT_W'(1);
		end
	end

	// ---- verdict output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pkt_end) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_end) begin
			verdict_q <= verdict_of(flags_nxt);
			tag_q     <= pkt.context_tag;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.verdict = verdict_q;
	assign res.tag_out = tag_q;

	// ---- checks ----
	`PSM_ASSERT_NEXT(a_end_gives_verdict, clk, arst_n, pkt_end, out_valid_q, "last beat without verdict")
	`PSM_ASSERT_NEXT(a_end_clears_state, clk, arst_n, pkt_end, (flags_q == '0) && (count_q == '0), "packet state not cleared")
	`PSM_ASSERT_NOW(a_count_bounded, clk, arst_n, 1'b1, CMP_W'(count_q) <= CMP_W'(SCAN_BYTES), "byte count past scan window")
	`PSM_ASSERT_NOW(a_stall_blocks_input, clk, arst_n, out_valid_q && !res.ready, !pkt.ready, "input taken over held verdict")

endmodule

// ----- test/tb_packet_signature_matcher.sv -----
// Testbench for packet_signature_matcher: random packets built from signature pieces and noise.
// Depends on psm_pkg, psm_if and the matcher RTL; checks every verdict beat against a predictor.
`timescale 1ns / 1ps

module tb_packet_signature_matcher;
	import psm_pkg::*;

	localparam int unsigned WIN_DEPTH    = 24;   // deeper than the longest signature
	localparam int unsigned STALL_LIMIT  = 2000; // cycles with no beat on either channel
	localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
	localparam int unsigned SEG_COUNT    = 6;
	localparam int unsigned SEG_BEATS    = 120;
	localparam int unsigned DRAIN_CYCLES = 10;

	// One expected verdict beat
	typedef struct packed {
		verdict_t         verdict;
		logic [TAG_W-1:0] tag;
	} verdict_beat_t;

	// Byte-serial predictor plus the queue of verdicts still owed by the block.
	class verdict_scoreboard;
		string            sig_text[SIG_COUNT];
		bit [7:0]         window[WIN_DEPTH]; // [0] is the newest byte
		int unsigned      scanned;
		bit [SIG_COUNT-1:0] seen;
		bit [LIMIT_W-1:0] limit;
		verdict_beat_t    verdicts_due[$];
		int unsigned      errors;

		function new();
			sig_text[SIG_SCRIPT]  = "/script";
			sig_text[SIG_RUNTIME] = "Runtime.getRuntime";
			sig_text[SIG_EXECUTE] = "execute";
			sig_text[SIG_CLI]     = "/cli?remoting";
			sig_text[SIG_FILE]    = "@/";
			limit = LIMIT_RESET;
			errors = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			foreach (window[i]) window[i] = 8'h00;
			scanned = 0;
			seen = '0;
		endfunction

		function void set_limit(bit [LIMIT_W-1:0] v);
			limit = v;
		endfunction

		// Signature must lie wholly inside the scanned bytes
		function bit tail_is(int unsigned s);
			int unsigned len;
			len = sig_text[s].len();
			if (len > scanned) return 1'b0;
			for (int unsigned k = 0; k < len; k++) begin
				if (window[k] != sig_text[s][len-1-k]) return 1'b0;
			end
			return 1'b1;
		endfunction

		function void take_byte(bit [7:0] b, bit last, bit [TAG_W-1:0] tag);
			int unsigned   eff;
			verdict_beat_t v;
			eff = (limit < SCAN_BYTES_DEF) ? limit : SCAN_BYTES_DEF;
			if (scanned < eff) begin
				for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
				window[0] = b;
				scanned++;
				for (int unsigned s = 0; s < SIG_COUNT; s++) begin
					if (tail_is(s)) seen[s] = 1'b1;
				end
			end
			if (last) begin
				if (seen[SIG_SCRIPT] && seen[SIG_RUNTIME]) begin
					v.verdict = VERDICT_SCRIPT_RUNTIME;
				end else if (seen[SIG_SCRIPT] && seen[SIG_EXECUTE]) begin
					v.verdict = VERDICT_SCRIPT_EXECUTE;
				end else if (seen[SIG_CLI] && seen[SIG_FILE]) begin
					v.verdict = VERDICT_CLI_FILE;
				end else begin
					v.verdict = VERDICT_NONE;
				end
				v.tag = tag;
				verdicts_due.push_back(v);
				clear_packet();
			end
		endfunction

		function void check_verdict(logic [1:0] verdict, logic [TAG_W-1:0] tag);
			verdict_beat_t want;
			if (verdicts_due.size() == 0) begin
				$error("unexpected verdict beat: verdict %0d tag_out %h", verdict, tag);
				errors++;
				return;
			end
			want = verdicts_due.pop_front();
			if (verdict !== want.verdict) begin
				$error("verdict: expected %0d, got %0d", want.verdict, verdict);
				errors++;
			end
			if (tag !== want.tag) begin
				$error("tag_out: expected %h, got %h", want.tag, tag);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;

	psm_in_if  pkt();
	psm_out_if res();

	packet_signature_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	verdict_scoreboard sb;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          hold_req;
	bit          hold_done;
	int unsigned stall_cycles;
	int unsigned beats_sent;
	bit [7:0]    pkt_buf[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Monitor both channels at the edge; watchdog on cycles with no beat at all.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pkt.valid && pkt.ready) begin
				sb.take_byte(pkt.data_byte, pkt.last_byte, pkt.context_tag);
			end
			if (res.valid && res.ready) begin
				sb.check_verdict(res.verdict, res.tag_out);
			end
			if ((pkt.valid && pkt.ready) || (res.valid && res.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				res.ready <= 1'b0;
				// block fills its output register and must stall the byte input
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			res.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Near-miss alphabet half the time, so partial signatures show up often
	function automatic bit [7:0] filler_byte();
		string near = "/@?.ecRrsu";
		if ($urandom_range(1)) return 8'($urandom_range(255));
		return near[$urandom_range(near.len() - 1)];
	endfunction

	function automatic void add_filler(int unsigned n);
		repeat (n) pkt_buf.push_back(filler_byte());
	endfunction

	// cut drops trailing characters to make a broken signature
	function automatic void add_text(string s, int unsigned cut);
		for (int unsigned i = 0; i + cut < s.len(); i++) pkt_buf.push_back(s[i]);
	endfunction

	// Two members of one verdict pair in either order, then maybe some stray signatures
	function automatic void add_pieces();
		int unsigned first_sig[3]  = '{SIG_SCRIPT, SIG_SCRIPT, SIG_CLI};
		int unsigned second_sig[3] = '{SIG_RUNTIME, SIG_EXECUTE, SIG_FILE};
		int unsigned pair;
		int unsigned pieces;
		int unsigned s;
		bit          swap;
		pair = $urandom_range(2);
		swap = $urandom_range(1);
		pieces = 2 + $urandom_range(2);
		for (int unsigned p = 0; p < pieces; p++) begin
			add_filler($urandom_range(3));
			if (p < 2) begin
				s = ((p == 0) ^ swap) ? first_sig[pair] : second_sig[pair];
			end else begin
				s = $urandom_range(SIG_COUNT - 1);
			end
			add_text(sb.sig_text[s], ($urandom_range(6) == 0) ? 1 : 0);
		end
	endfunction

	function automatic void build_packet();
		int unsigned k;
		pkt_buf.delete();
		k = $urandom_range(99);
		if (k < 2) begin
			// long packet: signatures straddle the scan window end
			add_filler($urandom_range(250, 225));
			add_pieces();
			add_filler($urandom_range(8));
		end else if (k < 78) begin
			add_pieces();
			add_filler($urandom_range(3));
		end else begin
			add_filler($urandom_range(24, 1));
		end
	endfunction

	task automatic send_beat(input bit [7:0] b, input bit last, input bit [TAG_W-1:0] tag);
		while ($urandom_range(99) < send_idle_pct) begin
			pkt.valid <= 1'b0;
			@(posedge clk);
		end
		pkt.valid       <= 1'b1;
		pkt.data_byte   <= b;
		pkt.last_byte   <= last;
		pkt.context_tag <= tag;
		do @(posedge clk); while (!pkt.ready);
		beats_sent++;
	endtask

	// Tag matters only on the last beat; the others carry noise
	task automatic send_packet(input bit [TAG_W-1:0] tag);
		int unsigned n;
		n = pkt_buf.size();
		for (int unsigned i = 0; i < n; i++) begin
			send_beat(pkt_buf[i], i == n - 1, (i == n - 1) ? tag : TAG_W'($urandom()));
		end
	endtask

	// Sender pauses until every verdict is back; sampled off the edge
	task automatic wait_drained();
		pkt.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_limit(input bit [LIMIT_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(v);
	endtask

	initial begin
		bit [LIMIT_W-1:0] seg_limit[SEG_COUNT];
		int unsigned      start;
		seg_limit       = '{9'd511, 9'd0, 9'd20, 9'd256, 9'd1, 9'd257};
		pkt.valid       = 1'b0;
		pkt.data_byte   = 8'h00;
		pkt.last_byte   = 1'b0;
		pkt.context_tag = '0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		arst_n          = 1'b0;
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		hold_req        = 1'b0;
		hold_done       = 1'b0;
		stall_cycles    = 0;
		beats_sent      = 0;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at the reset limit: cli+file hit on the very last byte
		pkt_buf.delete();
		add_text("@//cli?remoting", 0);
		send_packet(32'hFFFF_FFFF);
		// one-byte packets, byte and tag extremes
		pkt_buf.delete();
		pkt_buf.push_back(8'h00);
		send_packet(32'h0000_0000);
		pkt_buf.delete();
		pkt_buf.push_back(8'hFF);
		send_packet(32'h5555_AAAA);
		// script plus file alone gives no verdict
		pkt_buf.delete();
		add_text("/script@/", 0);
		send_packet(32'hAAAA_5555);
		wait_drained();

		// Random segments: limit above the scan size, zero, tight, exact, one, just over
		for (int unsigned seg = 0; seg < SEG_COUNT; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 26;
					recv_idle_pct = 48;
				end
				1: begin
					send_idle_pct = 48;
					recv_idle_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_limit(seg_limit[seg]);
			if (seg == 2) hold_req = 1'b1;
			start = beats_sent;
			while (beats_sent - start < SEG_BEATS) begin
				build_packet();
				send_packet(TAG_W'($urandom()));
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
